[sv/dpbp_pkg.sv]
// Shared types and constants for the depth pixel back-projection block.
// Used by dpbp_divider and depth_pixel_backprojection_top; depends on nothing.
package dpbp_pkg;

	// Field widths of one pixel request and one point result.
	localparam int COORD_W = 12;
	localparam int DEPTH_W = 16;
	localparam int MASK_W  = 8;
	localparam int COLOR_W = 8;
	localparam int POS_W   = 32;
	localparam int FOCAL_W = 16;
	localparam int CFG_W   = 16;

	localparam int IN_W  = 2 * COORD_W + DEPTH_W + MASK_W + 3 * COLOR_W;
	localparam int OUT_W = 2 * POS_W + DEPTH_W + 3 * COLOR_W;

	// Restoring division steps done by each divider pipeline stage.
	localparam int STEPS_PER_STAGE = 4;

	typedef enum logic [2:0] {
		REG_FOCAL_X    = 3'd0,
		REG_FOCAL_Y    = 3'd1,
		REG_CENTER_X   = 3'd2,
		REG_CENTER_Y   = 3'd3,
		REG_MASK_THR   = 3'd4,
		REG_DEPTH_MIN  = 3'd5,
		REG_DEPTH_MAX  = 3'd6
	} reg_idx_t;

	localparam logic [MASK_W-1:0]  MASK_THR_RESET  = 8'd128;
	localparam logic [DEPTH_W-1:0] DEPTH_MIN_RESET = 16'd100;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX_RESET = 16'd4000;

	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} color_t;

endpackage

[sv/dpbp_divider.sv]
// Pipelined restoring divider: unsigned numerator by a 16-bit divisor,
// several quotient bits per stage. Depends on dpbp_pkg.
module dpbp_divider #(
	parameter int NUM_W = 36,
	parameter int DEN_W = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	output logic [((NUM_W + dpbp_pkg::STEPS_PER_STAGE - 1) / dpbp_pkg::STEPS_PER_STAGE)
		* dpbp_pkg::STEPS_PER_STAGE - 1:0] quot
);
	import dpbp_pkg::*;

	localparam int STAGES = (NUM_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int PAD_W  = STAGES * STEPS_PER_STAGE;

	// Numerator bits leave the top of the shift word while quotient bits
	// enter at the bottom, so the last stage holds the whole quotient.
	logic [DEN_W-1:0] rem_s   [STAGES];
	logic [PAD_W-1:0] shift_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [PAD_W-1:0] shift_in;
		logic [DEN_W-1:0] rem_nx;
		logic [PAD_W-1:0] shift_nx;

		if (k == 0) begin : g_first
			assign rem_in   = '0;
			assign shift_in = PAD_W'(num);
		end else begin : g_next
			assign rem_in   = rem_s[k-1];
			assign shift_in = shift_s[k-1];
		end

		always_comb begin
			logic [DEN_W:0] trial;
			rem_nx   = rem_in;
			shift_nx = shift_in;
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				trial    = {rem_nx, shift_nx[PAD_W-1]};
				shift_nx = {shift_nx[PAD_W-2:0], 1'b0};
				if (trial >= {1'b0, den}) begin
					trial       = trial - {1'b0, den};
					shift_nx[0] = 1'b1;
				end
				rem_nx = trial[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]   <= rem_nx;
				shift_s[k] <= shift_nx;
			end
		end
	end

	assign quot = shift_s[STAGES-1];

endmodule

[sv/depth_pixel_backprojection_top.sv]
// Top level of the depth pixel back-projection block: filter, pinhole math,
// saturation and output skid buffer. Depends on dpbp_pkg and dpbp_divider.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  s_tdata: col, row, depth_mm, mask_level, red, green, blue
//  m_*      out  m_tvalid / m_tready  m_tdata: x_pos, y_pos, z_mm, red_out, green_out, blue_out
//  cfg_*    in   cfg_we               cfg_index, cfg_data (no read-back)
//
// One pixel request is accepted per clock while s_tready is high; it passes stage 1,
// stage 2, D = ceil((max(12 + FRACTION_BITS, 16) + 16 + FRACTION_BITS) / 4) divider
// stages (four quotient bits per stage) and the output register.
// Pixels that fail a check are dropped at the first stage and leave a bubble.
// The pipeline halts only when the output register and skid entry are both full.
// Reset clears all valid bits and sets the registers to their reset values.
module depth_pixel_backprojection_top #(
	parameter int FRACTION_BITS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// col[11:0], row[23:12], depth_mm[39:24], mask_level[47:40],
	// red[55:48], green[63:56], blue[71:64]
	input  logic [dpbp_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// x_pos[31:0], y_pos[63:32], z_mm[79:64], red_out[87:80],
	// green_out[95:88], blue_out[103:96]
	output logic [dpbp_pkg::OUT_W-1:0]  m_tdata,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [dpbp_pkg::CFG_W-1:0]  cfg_data
);
	import dpbp_pkg::*;

	localparam int SC_W   = (COORD_W + FRACTION_BITS > FOCAL_W) ?
		COORD_W + FRACTION_BITS : FOCAL_W;
	localparam int PROD_W = SC_W + DEPTH_W;
	localparam int NUM_W  = PROD_W + FRACTION_BITS;
	localparam int DIV_STAGES = (NUM_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int PAD_W  = DIV_STAGES * STEPS_PER_STAGE;
	localparam int EXT_W  = (PAD_W > POS_W + 1) ? PAD_W : POS_W + 1;

	// Configuration registers.
	logic [FOCAL_W-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [MASK_W-1:0]  mask_thr_q;
	logic [DEPTH_W-1:0] depth_min_q, depth_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q   <= '0;
			focal_y_q   <= '0;
			center_x_q  <= '0;
			center_y_q  <= '0;
			mask_thr_q  <= MASK_THR_RESET;
			depth_min_q <= DEPTH_MIN_RESET;
			depth_max_q <= DEPTH_MAX_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FOCAL_X:   focal_x_q   <= cfg_data[FOCAL_W-1:0];
				REG_FOCAL_Y:   focal_y_q   <= cfg_data[FOCAL_W-1:0];
				REG_CENTER_X:  center_x_q  <= cfg_data[FOCAL_W-1:0];
				REG_CENTER_Y:  center_y_q  <= cfg_data[FOCAL_W-1:0];
				REG_MASK_THR:  mask_thr_q  <= cfg_data[MASK_W-1:0];
				REG_DEPTH_MIN: depth_min_q <= cfg_data[DEPTH_W-1:0];
				REG_DEPTH_MAX: depth_max_q <= cfg_data[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Unpack the request.
	logic [COORD_W-1:0] in_col, in_row;
	logic [DEPTH_W-1:0] in_depth;
	logic [MASK_W-1:0]  in_mask;
	color_t             in_color;

	assign in_col   = s_tdata[COORD_W-1:0];
	assign in_row   = s_tdata[2*COORD_W-1:COORD_W];
	assign in_depth = s_tdata[2*COORD_W+DEPTH_W-1:2*COORD_W];
	assign in_mask  = s_tdata[2*COORD_W+DEPTH_W+MASK_W-1:2*COORD_W+DEPTH_W];
	assign in_color.red   = s_tdata[IN_W-2*COLOR_W-1:IN_W-3*COLOR_W];
	assign in_color.green = s_tdata[IN_W-COLOR_W-1:IN_W-2*COLOR_W];
	assign in_color.blue  = s_tdata[IN_W-1:IN_W-COLOR_W];

	logic skid_vld_q, out_vld_q;
	logic en;

	assign en       = !skid_vld_q;
	assign s_tready = en;

	// Stage 1: checks and signed offset from the principal point.
	logic pass;
	logic [SC_W-1:0] scaled_x, scaled_y;

	assign pass = (in_mask > mask_thr_q) && (in_depth > depth_min_q) &&
		(in_depth < depth_max_q) && (focal_x_q != '0) && (focal_y_q != '0);
	assign scaled_x = SC_W'(in_col) << FRACTION_BITS;
	assign scaled_y = SC_W'(in_row) << FRACTION_BITS;

	logic               vld_s1;
	logic               neg_x_s1, neg_y_s1;
	logic [SC_W-1:0]    mag_x_s1, mag_y_s1;
	logic [DEPTH_W-1:0] depth_s1;
	color_t             color_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid && pass;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_s1 <= scaled_x < SC_W'(center_x_q);
			neg_y_s1 <= scaled_y < SC_W'(center_y_q);
			mag_x_s1 <= (scaled_x < SC_W'(center_x_q)) ?
				SC_W'(center_x_q) - scaled_x : scaled_x - SC_W'(center_x_q);
			mag_y_s1 <= (scaled_y < SC_W'(center_y_q)) ?
				SC_W'(center_y_q) - scaled_y : scaled_y - SC_W'(center_y_q);
			depth_s1 <= in_depth;
			color_s1 <= in_color;
		end
	end

	// Stage 2: offset times depth.
	logic               vld_s2;
	logic               neg_x_s2, neg_y_s2;
	logic [PROD_W-1:0]  prod_x_s2, prod_y_s2;
	logic [DEPTH_W-1:0] depth_s2;
	color_t             color_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_s2  <= neg_x_s1;
			neg_y_s2  <= neg_y_s1;
			prod_x_s2 <= PROD_W'(mag_x_s1) * PROD_W'(depth_s1);
			prod_y_s2 <= PROD_W'(mag_y_s1) * PROD_W'(depth_s1);
			depth_s2  <= depth_s1;
			color_s2  <= color_s1;
		end
	end

	// Divider stages: the quotient magnitudes, with the sideband kept in step.
	logic [PAD_W-1:0] quot_x, quot_y;

	dpbp_divider #(
		.NUM_W (NUM_W),
		.DEN_W (FOCAL_W)
	) u_div_x (
		.clk  (clk),
		.en   (en),
		.num  (NUM_W'(prod_x_s2) << FRACTION_BITS),
		.den  (focal_x_q),
		.quot (quot_x)
	);

	dpbp_divider #(
		.NUM_W (NUM_W),
		.DEN_W (FOCAL_W)
	) u_div_y (
		.clk  (clk),
		.en   (en),
		.num  (NUM_W'(prod_y_s2) << FRACTION_BITS),
		.den  (focal_y_q),
		.quot (quot_y)
	);

	logic               vld_sd   [DIV_STAGES];
	logic               neg_x_sd [DIV_STAGES];
	logic               neg_y_sd [DIV_STAGES];
	logic [DEPTH_W-1:0] depth_sd [DIV_STAGES];
	color_t             color_sd [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				vld_sd[k] <= 1'b0;
			end
		end else if (en) begin
			vld_sd[0] <= vld_s2;
			for (int k = 1; k < DIV_STAGES; k++) begin
				vld_sd[k] <= vld_sd[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_sd[0] <= neg_x_s2;
			neg_y_sd[0] <= neg_y_s2;
			depth_sd[0] <= depth_s2;
			color_sd[0] <= color_s2;
			for (int k = 1; k < DIV_STAGES; k++) begin
				neg_x_sd[k] <= neg_x_sd[k-1];
				neg_y_sd[k] <= neg_y_sd[k-1];
				depth_sd[k] <= depth_sd[k-1];
				color_sd[k] <= color_sd[k-1];
			end
		end
	end

	// Sign and saturation. A negative result may reach -2^31 exactly.
	function automatic logic [POS_W-1:0] sat_pos(input logic [EXT_W-1:0] q, input logic neg);
		logic over_pos;
		logic over_neg;
		over_pos = |q[EXT_W-1:POS_W-1];
		over_neg = (|q[EXT_W-1:POS_W]) || (q[POS_W-1] && (|q[POS_W-2:0]));
		if (neg) begin
			sat_pos = over_neg ? {1'b1, {(POS_W-1){1'b0}}} : POS_W'(0) - q[POS_W-1:0];
		end else begin
			sat_pos = over_pos ? {1'b0, {(POS_W-1){1'b1}}} : q[POS_W-1:0];
		end
	endfunction

	logic [OUT_W-1:0] result;
	color_t           res_color;

	assign res_color = color_sd[DIV_STAGES-1];
	assign result = {res_color.blue, res_color.green, res_color.red,
		depth_sd[DIV_STAGES-1],
		sat_pos(EXT_W'(quot_y), neg_y_sd[DIV_STAGES-1]),
		sat_pos(EXT_W'(quot_x), neg_x_sd[DIV_STAGES-1])};

	// Output register plus one skid entry, so s_tready is a flop output.
	logic [OUT_W-1:0] out_data_q, skid_data_q;
	logic take, load_out_pipe, load_out_skid, load_skid;

	assign take          = out_vld_q && m_tready;
	assign load_out_pipe = !skid_vld_q && vld_sd[DIV_STAGES-1] && (!out_vld_q || take);
	assign load_skid     = !skid_vld_q && vld_sd[DIV_STAGES-1] && out_vld_q && !take;
	assign load_out_skid = skid_vld_q && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (load_out_pipe || load_out_skid) begin
				out_vld_q <= 1'b1;
			end else if (take) begin
				out_vld_q <= 1'b0;
			end
			if (load_skid) begin
				skid_vld_q <= 1'b1;
			end else if (load_out_skid) begin
				skid_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out_skid) begin
			out_data_q <= skid_data_q;
		end else if (load_out_pipe) begin
			out_data_q <= result;
		end
		if (load_skid) begin
			skid_data_q <= result;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// The skid entry is only ever occupied behind a held output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry full while output register empty");

	// A skid entry is filled only when the output was blocked the cycle before.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_tready))
		else $error("skid entry filled without a stalled output");

	// A pixel with a zero focal length never enters the pipeline.
	a_zero_focal_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (focal_x_q == '0 || focal_y_q == '0)) |=> !vld_s1)
		else $error("pixel with zero focal length marked valid");

	// While the pipeline is halted the last divider stage keeps its item.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_sd[DIV_STAGES-1]))
		else $error("pipeline moved while halted");

endmodule
